[hw/rtl/trie_longest_prefix_match_assert.svh]
// ----------------------------------------------------------------------------
// trie_longest_prefix_match_assert.svh
// Assertion macros used by the trie lookup RTL (tlpm_walk_ctrl).
// ----------------------------------------------------------------------------
`ifndef TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH
`define TRIE_LONGEST_PREFIX_MATCH_ASSERT_SVH

// Same-cycle implication.
`define TLPM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define TLPM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

[hw/rtl/tlpm_pkg.sv]
// ----------------------------------------------------------------------------
// tlpm_pkg
// Types and defaults for the trie longest-prefix-match block.
// ----------------------------------------------------------------------------
`default_nettype none

package tlpm_pkg;

  localparam int NODES_DEF       = 1024;
  localparam int ALPHABET_DEF    = 26;
  localparam int MAX_KEY_LEN_DEF = 64;

  typedef enum logic [1:0] {
    ACT_INSERT = 2'd0,
    ACT_SEARCH = 2'd1,
    ACT_PREFIX = 2'd2
  } action_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_WALK,
    ST_END_RD,
    ST_END_WB
  } state_t;

  typedef struct packed {
    logic [1:0] action;
    logic [4:0] letter;
    logic       last_letter;
  } key_item_t;

  typedef struct packed {
    logic [1:0] done_action;
    logic       found;
    logic [6:0] prefix_length;
    logic       pool_overflow;
  } res_item_t;

endpackage

`default_nettype wire

[hw/rtl/trie_longest_prefix_match.sv]
// Non-final letter: row read, ST_WALK, then the next item is taken (no walk once stopped).
// Final letter: ST_END_RD, then ST_END_WB registers the result once the output is free;
// no item is taken before that. Each walked letter reads its node row (one row per node);
// inserts write changed rows back. After rst a clear zeroes the row memory, key_stall high.
// Reset returns the pool to the root alone and drops any partial key.
// ----------------------------------------------------------------------------
// trie_longest_prefix_match
// Trie over a bounded node pool: insert, exact search and longest stored
// prefix, one key letter per item.
// ----------------------------------------------------------------------------
`default_nettype none

module trie_longest_prefix_match #(
  parameter int NODES       = tlpm_pkg::NODES_DEF,
  parameter int ALPHABET    = tlpm_pkg::ALPHABET_DEF,
  parameter int MAX_KEY_LEN = tlpm_pkg::MAX_KEY_LEN_DEF
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                key_valid,
  output logic                     key_stall,
  input  wire tlpm_pkg::key_item_t key_item,
  output logic                     res_valid,
  input  wire logic                res_stall,
  output tlpm_pkg::res_item_t      res_item
);

  import tlpm_pkg::*;

  localparam int NW    = $clog2(NODES);
  localparam int ROW_W = ALPHABET * NW + 1;

  logic             rd_en;
  logic [NW-1:0]    rd_addr;
  logic [ROW_W-1:0] rd_data;
  logic             wr_en;
  logic [NW-1:0]    wr_addr;
  logic [ROW_W-1:0] wr_data;

  tlpm_walk_ctrl #(
    .NODES      (NODES),
    .ALPHABET   (ALPHABET),
    .MAX_KEY_LEN(MAX_KEY_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .key_valid(key_valid),
    .key_stall(key_stall),
    .key_item (key_item),
    .res_valid(res_valid),
    .res_stall(res_stall),
    .res_item (res_item),
    .rd_en    (rd_en),
    .rd_addr  (rd_addr),
    .rd_data  (rd_data),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  tlpm_row_ram #(
    .DEPTH(NODES),
    .WIDTH(ROW_W)
  ) u_rows (
    .clk    (clk),
    .rd_en  (rd_en),
    .rd_addr(rd_addr),
    .rd_data(rd_data),
    .wr_en  (wr_en),
    .wr_addr(wr_addr),
    .wr_data(wr_data)
  );

endmodule

`default_nettype wire

[hw/rtl/tlpm_row_ram.sv]
// ----------------------------------------------------------------------------
// tlpm_row_ram
// One node row per address: word-end mark and child pointers.
// Simple dual-port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tlpm_row_ram #(
  parameter int DEPTH = 1024,
  parameter int WIDTH = 261
) (
  input  wire logic                     clk,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

[hw/rtl/tlpm_walk_ctrl.sv]
// ----------------------------------------------------------------------------
// tlpm_walk_ctrl
// Per-letter walk sequencer: row read, child allocate / follow, word-end
// update at key end, result register and post-reset row clear.
// ----------------------------------------------------------------------------
`default_nettype none

`include "trie_longest_prefix_match_assert.svh"

module tlpm_walk_ctrl #(
  parameter int NODES       = tlpm_pkg::NODES_DEF,
  parameter int ALPHABET    = tlpm_pkg::ALPHABET_DEF,
  parameter int MAX_KEY_LEN = tlpm_pkg::MAX_KEY_LEN_DEF
) (
  input  wire logic                                        clk,
  input  wire logic                                        rst,
  input  wire logic                                        key_valid,
  output logic                                             key_stall,
  input  wire tlpm_pkg::key_item_t                         key_item,
  output logic                                             res_valid,
  input  wire logic                                        res_stall,
  output tlpm_pkg::res_item_t                              res_item,
  output logic                                             rd_en,
  output logic [$clog2(NODES)-1:0]                         rd_addr,
  input  wire logic [ALPHABET*$clog2(NODES):0]             rd_data,
  output logic                                             wr_en,
  output logic [$clog2(NODES)-1:0]                         wr_addr,
  output logic [ALPHABET*$clog2(NODES):0]                  wr_data
);

  import tlpm_pkg::*;

  localparam int NW    = $clog2(NODES);
  localparam int AW    = $clog2(ALPHABET);
  localparam int LW    = $clog2(MAX_KEY_LEN + 1);
  localparam int ROW_W = ALPHABET * NW + 1;
  localparam logic [LW-1:0] MAX_LW     = LW'(MAX_KEY_LEN);
  localparam logic [NW:0]   NODES_FULL = (NW+1)'(NODES);
  localparam logic [NW-1:0] LAST_ROW   = NW'(NODES - 1);

  state_t        state, state_next;
  action_t       key_action, key_action_next;
  logic [LW-1:0] letters_seen, letters_seen_next;
  logic [LW-1:0] best, best_next;
  logic          stopped, stopped_next;
  logic          failed, failed_next;
  logic          pend, pend_next;
  logic [NW-1:0] cur, cur_next;
  logic [NW:0]   next_free, next_free_next;
  logic [4:0]    letter, letter_next;
  logic          last, last_next;
  logic [NW-1:0] clr_addr, clr_addr_next;
  logic          res_valid_next;
  res_item_t     res_item_next;

  logic                         fresh;
  logic                         out_free;
  logic                         mark;
  logic [ALPHABET-1:0][NW-1:0]  kids;
  logic [ALPHABET-1:0][NW-1:0]  kids_wr;
  logic                         letter_ok;
  logic [AW-1:0]                slot;
  logic [NW-1:0]                child;
  logic                         hit;

  assign fresh     = (letters_seen == '0);
  assign out_free  = !res_valid || !res_stall;
  assign mark      = rd_data[ROW_W-1];
  assign kids      = rd_data[ROW_W-2:0];
  assign letter_ok = (32'(letter) < ALPHABET);
  assign slot      = AW'(letter);
  assign child     = letter_ok ? kids[slot] : '0;
  assign hit       = pend && mark;
  assign key_stall = (state != ST_IDLE);

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      key_action   <= ACT_INSERT;
      letters_seen <= '0;
      best         <= '0;
      stopped      <= 1'b0;
      failed       <= 1'b0;
      pend         <= 1'b0;
      cur          <= '0;
      next_free    <= (NW+1)'(1);
      clr_addr     <= '0;
      res_valid    <= 1'b0;
    end else begin
      state        <= state_next;
      key_action   <= key_action_next;
      letters_seen <= letters_seen_next;
      best         <= best_next;
      stopped      <= stopped_next;
      failed       <= failed_next;
      pend         <= pend_next;
      cur          <= cur_next;
      next_free    <= next_free_next;
      clr_addr     <= clr_addr_next;
      res_valid    <= res_valid_next;
    end
  end

  always_ff @(posedge clk) begin
    letter   <= letter_next;
    last     <= last_next;
    res_item <= res_item_next;
  end

  always_comb begin
    state_next        = state;
    key_action_next   = key_action;
    letters_seen_next = letters_seen;
    best_next         = best;
    stopped_next      = stopped;
    failed_next       = failed;
    pend_next         = pend;
    cur_next          = cur;
    next_free_next    = next_free;
    letter_next       = letter;
    last_next         = last;
    clr_addr_next     = clr_addr;
    res_valid_next    = res_valid && res_stall;
    res_item_next     = res_item;
    rd_en             = 1'b0;
    rd_addr           = cur;
    wr_en             = 1'b0;
    wr_addr           = cur;
    kids_wr           = kids;
    wr_data           = rd_data;

    case (state)
      ST_CLEAR: begin
        wr_en         = 1'b1;
        wr_addr       = clr_addr;
        wr_data       = '0;
        clr_addr_next = NW'(clr_addr + 1'b1);
        if (clr_addr == LAST_ROW) begin
          state_next = ST_IDLE;
        end
      end

      ST_IDLE: begin
        if (key_valid) begin
          letter_next = key_item.letter;
          last_next   = key_item.last_letter;
          if (fresh) begin
            key_action_next = (key_item.action inside {ACT_INSERT, ACT_SEARCH, ACT_PREFIX})
                              ? action_t'(key_item.action) : ACT_SEARCH;
            stopped_next    = 1'b0;
            failed_next     = 1'b0;
            best_next       = '0;
            pend_next       = 1'b0;
            cur_next        = '0;
          end
          if (fresh || (letters_seen < MAX_LW && !stopped)) begin
            rd_en      = 1'b1;
            rd_addr    = fresh ? '0 : cur;
            state_next = ST_WALK;
          end else begin
            if (letters_seen < MAX_LW) begin
              letters_seen_next = LW'(letters_seen + 1'b1);
            end
            if (key_item.last_letter) begin
              state_next = ST_END_RD;
            end
          end
        end
      end

      ST_WALK: begin
        letters_seen_next = LW'(letters_seen + 1'b1);
        if (key_action == ACT_INSERT) begin
          if (!letter_ok) begin
            stopped_next = 1'b1;
          end else if (child == '0) begin
            if (next_free >= NODES_FULL) begin
              failed_next  = 1'b1;
              stopped_next = 1'b1;
            end else begin
              kids_wr[slot]  = next_free[NW-1:0];
              wr_en          = 1'b1;
              wr_addr        = cur;
              wr_data        = {mark, kids_wr};
              cur_next       = next_free[NW-1:0];
              next_free_next = (NW+1)'(next_free + 1'b1);
            end
          end else begin
            cur_next = child;
          end
        end else begin
          // deferred word-end check of the node entered on the previous letter
          if (hit) begin
            best_next = letters_seen;
          end
          if (child == '0) begin
            stopped_next = 1'b1;
            pend_next    = 1'b0;
          end else begin
            cur_next  = child;
            pend_next = 1'b1;
          end
        end
        state_next = last ? ST_END_RD : ST_IDLE;
      end

      ST_END_RD: begin
        rd_en      = 1'b1;
        rd_addr    = cur;
        state_next = ST_END_WB;
      end

      ST_END_WB: begin
        if (out_free) begin
          res_valid_next            = 1'b1;
          res_item_next.done_action = key_action;
          if (key_action == ACT_INSERT) begin
            res_item_next.found         = !stopped;
            res_item_next.prefix_length = '0;
            res_item_next.pool_overflow = failed;
            if (!stopped) begin
              wr_en   = 1'b1;
              wr_addr = cur;
              wr_data = {1'b1, kids};
            end
          end else begin
            res_item_next.found         = !stopped && mark;
            res_item_next.prefix_length = hit ? 7'(letters_seen) : 7'(best);
            res_item_next.pool_overflow = 1'b0;
          end
          letters_seen_next = '0;
          pend_next         = 1'b0;
          state_next        = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  `TLPM_ASSERT_NOW(a_no_rw_overlap, clk, rst, rd_en, !wr_en,
                   "row read and write in the same cycle")
  `TLPM_ASSERT_NOW(a_free_bound, clk, rst, 1'b1, next_free <= NODES_FULL,
                   "free node counter past pool size")
  `TLPM_ASSERT_NOW(a_cur_allocated, clk, rst, 1'b1, (NW+1)'(cur) < next_free,
                   "current node not allocated")
  `TLPM_ASSERT_NEXT(a_key_close, clk, rst, state == ST_END_WB && out_free,
                    res_valid && letters_seen == '0 && state == ST_IDLE,
                    "key end did not post a result item")

endmodule

`default_nettype wire

[sim/trie_longest_prefix_match_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trie_longest_prefix_match_tb
// Feeds key letters for insert, exact search and longest-prefix lookups and
// checks every result item against a trie kept inside the bench. Covers
// empty-trie lookups, the spare action code, actions that change mid-key,
// letters outside the alphabet and keys longer than the limit. Both sides
// idle in random bursts, with one long output hold.
// ----------------------------------------------------------------------------

module trie_longest_prefix_match_tb;
  import tlpm_pkg::*;

  localparam int NODES        = NODES_DEF;
  localparam int ALPHA        = ALPHABET_DEF;
  localparam int KEYMAX       = MAX_KEY_LEN_DEF;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 12;
  localparam int HOLD_CYCLES  = 200;
  localparam int WORDS_MAX    = 512;
  localparam int WORD_LEN_MAX = 8;
  localparam logic [1:0] ACT_SPARE = 2'd3;
  localparam byte LETTER_BASE = "a";

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  logic      key_valid = 1'b0;
  logic      key_stall;
  key_item_t key_item = '0;
  logic      res_valid;
  logic      res_stall = 1'b0;
  res_item_t res_item;

  trie_longest_prefix_match dut (
    .clk       (clk),
    .rst       (rst),
    .key_valid (key_valid),
    .key_stall (key_stall),
    .key_item  (key_item),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .res_item  (res_item)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // bench copy of the trie
  logic [9:0]  trie_child [NODES*ALPHA];
  bit          word_end [NODES];
  int unsigned free_node, cur_node, taken, best_len;
  bit          halted, ran_out;
  action_t     key_act;

  key_item_t key_pending [$];
  res_item_t result_due [$];

  int  errors = 0;
  int  items_sent = 0;
  int  cycle_count = 0;
  bit  idle_on = 1'b1;
  int  hold_asks = 0;
  int  hold_done = 0;
  int  hold_left = 0;
  int  send_gap = 0;
  int  stall_gap = 0;
  bit  took;
  res_item_t due, res_want;

  logic [4:0] key_buf [0:127];
  logic [4:0] known_letters [0:WORDS_MAX-1][0:WORD_LEN_MAX-1];
  int         known_len [0:WORDS_MAX-1];
  int         known_count = 0;

  function automatic void trie_reset();
    for (int i = 0; i < NODES*ALPHA; i++) trie_child[i] = '0;
    for (int i = 0; i < NODES; i++) word_end[i] = 1'b0;
    free_node = 1;
    cur_node  = 0;
    taken     = 0;
    best_len  = 0;
    halted    = 1'b0;
    ran_out   = 1'b0;
    key_act   = ACT_INSERT;
  endfunction

  // one letter through the trie; returns 1 when the key finishes
  function automatic bit trie_take_letter(input key_item_t it, output res_item_t r);
    int unsigned slot, child;
    bit in_range;
    r = '0;
    if (taken == 0) begin
      key_act  = (it.action > 2'd2) ? ACT_SEARCH : action_t'(it.action);
      cur_node = 0;
      best_len = 0;
      halted   = 1'b0;
      ran_out  = 1'b0;
    end
    if (taken < KEYMAX) begin
      taken++;
      if (!halted) begin
        in_range = it.letter < ALPHA;
        slot     = cur_node * ALPHA + it.letter;
        child    = in_range ? trie_child[slot] : 0;
        if (key_act == ACT_INSERT) begin
          if (!in_range) begin
            halted = 1'b1;
          end else if (child == 0) begin
            if (free_node >= NODES) begin
              ran_out = 1'b1;
              halted  = 1'b1;
            end else begin
              child = free_node;
              free_node++;
              trie_child[slot] = 10'(child);
            end
          end
          if (!halted) cur_node = child;
        end else if (child == 0) begin
          halted = 1'b1;
        end else begin
          cur_node = child;
          if (word_end[cur_node]) best_len = taken;
        end
      end
    end
    if (!it.last_letter) return 1'b0;
    r.done_action = key_act;
    if (key_act == ACT_INSERT) begin
      if (!halted) word_end[cur_node] = 1'b1;
      r.found         = !halted;
      r.pool_overflow = ran_out;
    end else begin
      r.found         = !halted && word_end[cur_node];
      r.prefix_length = best_len[6:0];
    end
    taken = 0;
    return 1'b1;
  endfunction

  function automatic void check_field(input string what, input int want, input int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s expected %0d actual %0d", $time, what, want, got);
    end
  endfunction

  // sender
  always @(posedge clk) begin
    if (rst) begin
      key_valid <= 1'b0;
    end else begin
      took = key_valid && !key_stall;
      if (took) begin
        if (trie_take_letter(key_item, due)) result_due.push_back(due);
      end
      if (!key_valid || took) begin
        if (send_gap > 0) begin
          send_gap--;
          key_valid <= 1'b0;
        end else if (key_pending.size() > 0) begin
          key_item  <= key_pending.pop_front();
          key_valid <= 1'b1;
          if (idle_on && $urandom_range(0, 6) == 0) send_gap = $urandom_range(1, 9);
        end else begin
          key_valid <= 1'b0;
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall) begin
      if (result_due.size() == 0) begin
        errors++;
        $display("%0t: result with none expected, actual %p", $time, res_item);
      end else begin
        res_want = result_due.pop_front();
        check_field("done_action", res_want.done_action, res_item.done_action);
        check_field("found", res_want.found, res_item.found);
        check_field("prefix_length", res_want.prefix_length, res_item.prefix_length);
        check_field("pool_overflow", res_want.pool_overflow, res_item.pool_overflow);
      end
    end
    if (hold_done != hold_asks) begin
      hold_done = hold_asks;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      res_stall <= 1'b1;
    end else if (stall_gap > 0) begin
      stall_gap--;
      res_stall <= 1'b1;
    end else begin
      res_stall <= 1'b0;
      if (idle_on && $urandom_range(0, 6) == 0) stall_gap = $urandom_range(1, 9);
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("trie_longest_prefix_match_tb: done, errors");
      $finish;
    end
  end

  function automatic logic [4:0] draw_letter();
    if ($urandom_range(0, 9) < 6) return 5'($urandom_range(0, 3));
    return 5'($urandom_range(0, ALPHA - 1));
  endfunction

  function automatic void fill_letters(input int from, input int upto);
    for (int i = from; i < upto; i++) key_buf[i] = draw_letter();
  endfunction

  function automatic int load_known();
    int pick;
    if (known_count == 0) return 0;
    pick = $urandom_range(0, known_count - 1);
    for (int i = 0; i < known_len[pick]; i++) key_buf[i] = known_letters[pick][i];
    return known_len[pick];
  endfunction

  task automatic queue_key(input logic [1:0] act, input int len, input bit drift);
    key_item_t it;
    for (int i = 0; i < len; i++) begin
      it.action      = (drift && i > 0) ? 2'($urandom_range(0, 3)) : act;
      it.letter      = key_buf[i];
      it.last_letter = (i == len - 1);
      key_pending.push_back(it);
    end
    items_sent += len;
  endtask

  task automatic queue_text(input logic [1:0] act, input string s, input bit drift);
    for (int i = 0; i < s.len(); i++) key_buf[i] = 5'(s[i] - LETTER_BASE);
    queue_key(act, s.len(), drift);
  endtask

  task automatic queue_random_key();
    int r, len, grow;
    logic [1:0] act;
    bit drift;
    r     = $urandom_range(0, 99);
    drift = 1'b0;
    act   = ($urandom_range(0, 9) == 0) ? ACT_SPARE : ACT_SEARCH;
    len   = load_known();
    if (r < 35) begin
      act = ACT_INSERT;
      if (len > 0 && $urandom_range(0, 1) == 0) begin
        grow = len + $urandom_range(0, 2);
        if (grow > WORD_LEN_MAX) grow = WORD_LEN_MAX;
        fill_letters(len, grow);
        len = grow;
      end else begin
        len = $urandom_range(1, 6);
        fill_letters(0, len);
      end
      if (known_count < WORDS_MAX) begin
        for (int i = 0; i < len; i++) known_letters[known_count][i] = key_buf[i];
        known_len[known_count] = len;
        known_count++;
      end
    end else if (r < 60) begin
      if (len == 0 || $urandom_range(0, 3) == 0) begin
        len = $urandom_range(1, 5);
        fill_letters(0, len);
      end else begin
        case ($urandom_range(0, 2))
          0: if (len > 1) len--;
          1: begin
            fill_letters(len, len + 1);
            len++;
          end
          default: ;
        endcase
      end
    end else if (r < 88) begin
      act  = ACT_PREFIX;
      grow = len + $urandom_range(0, 4);
      if (grow == 0) grow = 1;
      fill_letters(len, grow);
      len = grow;
    end else if (r < 98) begin
      act   = 2'($urandom_range(0, 3));
      drift = $urandom_range(0, 1);
      len   = $urandom_range(1, 8);
      for (int i = 0; i < len; i++) key_buf[i] = 5'($urandom_range(0, 31));
    end else begin
      act  = 2'($urandom_range(0, 2));
      grow = $urandom_range(KEYMAX + 1, KEYMAX + 6);
      fill_letters(len, grow);
      len = grow;
    end
    queue_key(act, len, drift);
  endtask

  task automatic wait_quiet();
    while (key_pending.size() != 0 || key_valid || result_due.size() != 0)
      @(negedge clk);
  endtask

  initial begin
    int target;
    trie_reset();
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    queue_text(ACT_SEARCH, "ab", 1'b0);
    queue_text(ACT_INSERT, "z", 1'b0);
    queue_text(ACT_INSERT, "ab", 1'b0);
    queue_text(ACT_PREFIX, "abz", 1'b0);
    queue_text(ACT_SPARE, "ab", 1'b0);
    queue_text(ACT_INSERT, "zy", 1'b1);
    queue_text(ACT_INSERT, "a~", 1'b0);
    queue_text(ACT_SEARCH, "a{", 1'b0);
    queue_text(ACT_PREFIX, "zyx", 1'b0);
    queue_text(ACT_SEARCH, "q", 1'b0);
    wait_quiet();

    while (items_sent < 180) queue_random_key();
    hold_asks++;
    wait_quiet();
    while (items_sent < 260) queue_random_key();
    wait_quiet();

    // full-length word, then lookups on and past the limit
    fill_letters(0, KEYMAX + 3);
    queue_key(ACT_INSERT, KEYMAX, 1'b0);
    queue_key(ACT_PREFIX, KEYMAX + 3, 1'b0);
    queue_key(ACT_SEARCH, KEYMAX, 1'b0);
    wait_quiet();

    idle_on = 1'b0;
    target  = items_sent + 100;
    while (items_sent < target) queue_random_key();
    wait_quiet();
    repeat (DRAIN_CYCLES) @(posedge clk);

    errors += result_due.size();
    if (errors == 0) begin
      $display("trie_longest_prefix_match_tb: done, clean");
    end else begin
      $display("trie_longest_prefix_match_tb: done, errors");
    end
    $finish;
  end

endmodule

[trie_longest_prefix_match.f]
+incdir+hw/rtl
hw/rtl/tlpm_pkg.sv
hw/rtl/tlpm_row_ram.sv
hw/rtl/tlpm_walk_ctrl.sv
hw/rtl/trie_longest_prefix_match.sv
sim/trie_longest_prefix_match_tb.sv
